[rtl/core/sbd_pkg.sv]
// shared types and codes for the seven-bit block deframer
`timescale 1ns / 1ps

package sbd_pkg;

  localparam int unsigned GroupLen = 8;
  localparam int unsigned PayloadWidth = 7;
  localparam int unsigned PhaseWidth = 3;
  localparam logic [PhaseWidth-1:0] PhaseLast = 3'd7;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_TOO_SHORT  = 3'd1,
    STATUS_NOT_MULT   = 3'd2,
    STATUS_NO_START   = 3'd3,
    STATUS_START_IN   = 3'd4
  } status_t;

  typedef struct packed {
    logic [PhaseWidth-1:0]   phase;
    logic [PayloadWidth-1:0] carry;
    logic                    full_seen;
    logic                    start_missing;
    logic                    start_inside;
  } state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       byte_valid;
    status_t    status;
    logic       frame_end;
  } result_t;

endpackage

[rtl/core/sbd_unpack.sv]
// unpack step: one wire byte against the carry state gives next state and result
`timescale 1ns / 1ps

module sbd_unpack (
  input  sbd_pkg::state_t  state,
  input  logic [7:0]       wire_byte,
  input  logic             last_byte,
  output sbd_pkg::state_t  state_next,
  output sbd_pkg::result_t result
);

  logic [6:0]  payload;
  logic        flag;
  logic [2:0]  p;
  logic [7:0]  carry_shift;
  logic [6:0]  payload_shift;
  sbd_pkg::state_t upd;

  assign payload = wire_byte[6:0];
  assign flag    = wire_byte[7];
  assign p       = state.phase;

  // bits shifted past the top of the message byte are dropped
  assign carry_shift   = {1'b0, state.carry} << p;
  assign payload_shift = payload >> (3'd7 - p);

  always_comb begin
    upd = state;
    // first byte of a frame opens group zero with nothing seen yet
    if (p == '0 && !state.full_seen) begin
      upd.start_missing = !flag;
    end else if (flag) begin
      upd.start_inside = 1'b1;
    end

    result.out_byte   = 8'd0;
    result.byte_valid = 1'b0;
    if (p == '0) begin
      upd.carry = payload;
    end else begin
      result.out_byte   = carry_shift | {1'b0, payload_shift};
      result.byte_valid = 1'b1;
      upd.carry         = payload & (7'h7f >> p);
    end

    if (p == sbd_pkg::PhaseLast) begin
      upd.full_seen = 1'b1;
      upd.phase     = '0;
    end else begin
      upd.phase = p + 3'd1;
    end

    result.status = sbd_pkg::STATUS_OK;
    if (last_byte) begin
      if (!upd.full_seen) begin
        result.status = sbd_pkg::STATUS_TOO_SHORT;
      end else if (upd.phase != '0) begin
        result.status = sbd_pkg::STATUS_NOT_MULT;
      end else if (upd.start_missing) begin
        result.status = sbd_pkg::STATUS_NO_START;
      end else if (upd.start_inside) begin
        result.status = sbd_pkg::STATUS_START_IN;
      end
      state_next = '0;
    end else begin
      state_next = upd;
    end

    result.frame_end = last_byte;
    result.emit      = result.byte_valid | last_byte;
  end

endmodule

[rtl/core/seven_bit_block_deframer.sv]
// Seven-bit block deframer: takes one wire byte per item (start flag in bit 7,
// seven payload bits below) and gives out recovered message bytes, seven for
// every eight wire bytes, with a frame status on the item marked by tlast.
// Sustained rate is one item per cycle on input while m_tready does not stall the
// output; a wire byte lands in the input register when it is accepted and its
// result is loaded into the result register when that register is free.
// The only state carried between items is the phase, carry and frame flag
// register updated in that single step. Wire bytes that open a group give no
// result unless they end the frame.
`timescale 1ns / 1ps

module seven_bit_block_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // wire_byte[7:0]
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic [3:0] m_tuser,   // byte_valid[0], frame_status[3:1]
  output logic       m_tlast    // frame_end
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       out_free;

  sbd_pkg::state_t  state;
  sbd_pkg::state_t  state_next;
  sbd_pkg::result_t result;

  sbd_unpack u_unpack (
    .state      (state),
    .wire_byte  (in_byte),
    .last_byte  (in_last),
    .state_next (state_next),
    .result     (result)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      m_tdata <= result.out_byte;
      m_tuser <= {result.status, result.byte_valid};
      m_tlast <= result.frame_end;
    end
  end

  // status is only reported on the frame end
  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[3:1] == sbd_pkg::STATUS_OK)
    else $error("frame status set away from frame end");

  // an item without a byte exists only to close a frame
  a_empty_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty result without frame end");

  // a frame end returns the unpack state to its start
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> state == '0)
    else $error("state not cleared after frame end");

  // a stalled result is never overwritten
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule
